// ===== rtl/msfc_pkg.sv =====
// Shared types and constants for the multiplier/shift factor calculator.
`default_nettype none

package msfc_pkg;

  // Width of the rate words and of the multiplier.
  localparam int unsigned WordBits = 32;
  // Width of the shift and budget fields.
  localparam int unsigned ShiftBits = 6;
  // Width of the dividend and quotient of one trial.
  localparam int unsigned DvdBits = 2 * WordBits;

  // Largest trial shift; trials run from here down to one.
  localparam logic [ShiftBits-1:0] TrialShiftMax = ShiftBits'(WordBits);
  // Shift budget when the range product has no bits above the low word.
  localparam logic [ShiftBits-1:0] BudgetFull = ShiftBits'(WordBits);
  // Default time span in seconds.
  localparam logic [WordBits-1:0] RangeResetVal = WordBits'(3600);

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_BLEN  = 6'b000100,
    ST_LOAD  = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_CHECK = 6'b100000
  } msfc_state_t;

endpackage : msfc_pkg

`default_nettype wire

// ===== rtl/mult_shift_factor_calculator.sv =====
// Multiplier/shift factor calculator: shift budget search and trial divisions.
//
// Usage: pulse start with in_source_rate and in_target_rate while busy is low;
// the request is taken at that edge and, for a nonzero source rate, busy rises
// on the next cycle. The result (out_multiplier, out_shift, out_div_error) is
// shown for exactly one cycle with out_valid high; the receiver cannot stall
// it, so it must capture the result in that cycle. busy falls in the same
// cycle that out_valid rises.
// cfg_wr_en/cfg_wr_data write range_seconds; write only while busy is low.
//
// Sequence: a zero source rate returns its error result in the cycle after the
// request. Otherwise: a multiply step, then the bit length L of the upper
// product word is taken one bit per cycle, then each trial shift runs a
// dividend load, 64 restoring-division steps and a fit check, with up to
// 32 trials; the result shows in the cycle after the last fit check. One
// request at a time; the shared divider sets the rate.
//
// Reset: synchronous active-low rst_n returns the sequencer to idle, drops
// out_valid and sets range_seconds to 3600.
`default_nettype none

module mult_shift_factor_calculator
  import msfc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request channel
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [WordBits-1:0]  in_source_rate,
  input  wire logic [WordBits-1:0]  in_target_rate,
  // result channel
  output logic                      out_valid,
  output logic [WordBits-1:0]       out_multiplier,
  output logic [ShiftBits-1:0]      out_shift,
  output logic                      out_div_error,
  // configuration
  input  wire logic                 cfg_wr_en,
  input  wire logic [WordBits-1:0]  cfg_wr_data
);

  msfc_state_t            state_r, state_nxt;
  logic [WordBits-1:0]    range_r;
  logic [WordBits-1:0]    src_r, tgt_r;
  logic [WordBits-1:0]    hi_r;
  logic [ShiftBits-1:0]   blen_r;
  logic [ShiftBits-1:0]   budget_r;
  logic [ShiftBits-1:0]   shift_r;
  logic [ShiftBits-1:0]   cnt_r;
  logic [DvdBits-1:0]     dvd_r;
  logic [WordBits-1:0]    rem_r;
  logic                   out_valid_r;
  logic [WordBits-1:0]    out_mult_r;
  logic [ShiftBits-1:0]   out_shift_r;
  logic                   out_err_r;

  logic                   accept;
  logic [DvdBits-1:0]     prod;
  logic [DvdBits-1:0]     tgt_sh;
  logic [DvdBits-1:0]     dvd_load;
  logic [WordBits:0]      rem_sh;
  logic [WordBits:0]      rem_diff;
  logic                   q_bit;
  logic [DvdBits-1:0]     q_hi;
  logic                   fits;
  logic                   div_last;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // range product, upper word only is kept
  assign prod = {{WordBits{1'b0}}, range_r} * {{WordBits{1'b0}}, src_r};

  // trial dividend: (target << shift) + source/2
  assign tgt_sh   = {{WordBits{1'b0}}, tgt_r} << shift_r;
  assign dvd_load = tgt_sh + {{(WordBits + 1){1'b0}}, src_r[WordBits-1:1]};

  // one restoring-division step
  assign rem_sh   = {rem_r, dvd_r[DvdBits-1]};
  assign rem_diff = rem_sh - {1'b0, src_r};
  assign q_bit    = ~rem_diff[WordBits];
  assign div_last = (cnt_r == ShiftBits'(DvdBits - 1));

  // quotient fits when no bit lies at or above the budget
  assign q_hi = dvd_r >> budget_r;
  assign fits = (q_hi == '0);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && (in_source_rate != '0)) state_nxt = ST_MUL;
      end
      ST_MUL:   state_nxt = ST_BLEN;
      ST_BLEN: begin
        if (hi_r == '0) state_nxt = ST_LOAD;
      end
      ST_LOAD:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_last) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (fits || (shift_r == ShiftBits'(1))) state_nxt = ST_IDLE;
        else state_nxt = ST_LOAD;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (accept && (in_source_rate == '0)) ||
                     ((state_r == ST_CHECK) && (fits || (shift_r == ShiftBits'(1))));
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= RangeResetVal;
    end else if (cfg_wr_en) begin
      range_r <= cfg_wr_data;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          src_r       <= in_source_rate;
          tgt_r       <= in_target_rate;
          out_mult_r  <= '0;
          out_shift_r <= '0;
          out_err_r   <= 1'b1;
        end
      end
      ST_MUL: begin
        hi_r   <= prod[DvdBits-1:WordBits];
        blen_r <= '0;
      end
      ST_BLEN: begin
        if (hi_r != '0) begin
          hi_r   <= hi_r >> 1;
          blen_r <= blen_r + ShiftBits'(1);
        end else begin
          budget_r <= BudgetFull - blen_r;
          shift_r  <= TrialShiftMax;
        end
      end
      ST_LOAD: begin
        dvd_r <= dvd_load;
        rem_r <= '0;
        cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r <= q_bit ? rem_diff[WordBits-1:0] : rem_sh[WordBits-1:0];
        dvd_r <= {dvd_r[DvdBits-2:0], q_bit};
        cnt_r <= cnt_r + ShiftBits'(1);
      end
      ST_CHECK: begin
        if (fits || (shift_r == ShiftBits'(1))) begin
          out_mult_r  <= dvd_r[WordBits-1:0];
          out_shift_r <= fits ? shift_r : '0;
          out_err_r   <= 1'b0;
        end else begin
          shift_r <= shift_r - ShiftBits'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_multiplier = out_mult_r;
  assign out_shift      = out_shift_r;
  assign out_div_error  = out_err_r;

  // a zero source rate answers with an error on the next cycle
  a_zero_src_err: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_source_rate == '0) |=> out_valid && out_div_error)
    else $error("zero source rate did not give an error result");

  // a nonzero source rate starts the sequencer
  a_nonzero_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_source_rate != '0) |=> busy && !out_valid)
    else $error("nonzero source rate did not start a calculation");

  // an error result carries zero multiplier and shift
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_error |-> (out_multiplier == '0) && (out_shift == '0))
    else $error("error result with nonzero payload");

  // shift never exceeds the largest trial, and a chosen shift fit its budget
  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_div_error && (out_shift != '0) |->
      (out_shift <= TrialShiftMax) && $past(fits))
    else $error("result shift out of range or not within budget");

  // the last division step leads to the fit check
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && div_last |=> (state_r == ST_CHECK))
    else $error("division did not end after its last step");

endmodule : mult_shift_factor_calculator

`default_nettype wire
